>>> sv/clld_pkg.sv
package clld_pkg;

   // Parser mode for the current entry.
   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_CONTENT = 2'd1,
      MODE_STOPPED = 2'd2
   } mode_type;

   // What the current header line has been recognized as.
   typedef enum logic [2:0] {
      LINE_UNDECIDED = 3'd0,
      LINE_LENGTH    = 3'd1,
      LINE_TIME      = 3'd2,
      LINE_EVENT     = 3'd3,
      LINE_OTHER     = 3'd4
   } line_kind_type;

   // Scan state of the number on a length or time line.
   typedef enum logic [2:0] {
      NUM_START  = 3'd0,
      NUM_MINUS  = 3'd1,
      NUM_POS    = 3'd2,
      NUM_NEG    = 3'd3,
      NUM_DONE   = 3'd4,
      NUM_BROKEN = 3'd5
   } num_status_type;

   // Outcome of the last length line of the entry.
   typedef enum logic [1:0] {
      LEN_UNSET = 2'd0,
      LEN_VALID = 2'd1,
      LEN_BAD   = 2'd2,
      LEN_LARGE = 2'd3
   } len_status_type;

   typedef enum logic [1:0] {
      RESULT_HEADER = 2'd0,
      RESULT_BYTE   = 2'd1,
      RESULT_ERROR  = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ERR_TRUNCATED  = 2'd0,
      ERR_BAD_LENGTH = 2'd1,
      ERR_TOO_LARGE  = 2'd2
   } error_code_type;

   // One result item as it sits in the output queue.
   typedef struct packed {
      result_kind_type kind;
      logic [63:0]     time_us;
      logic [1:0]      event_kind;
      logic [31:0]     content_length;
      logic [7:0]      content_byte;
      logic            last;
      error_code_type  error_code;
   } rsp_item_type;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 112;
   localparam int RSP_USER_BITS = 2;

   localparam int RSP_QUEUE_DEPTH    = 4;
   localparam int RSP_QUEUE_PTR_BITS = 2;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Header prefixes, first character in the top byte, padded at the bottom.
   // The time and event prefixes are the vendor "X-...-Time: " and
   // "X-...-Event: " lines, spelled out in hex.
   localparam logic [127:0] HDR_LENGTH_TEXT = "Content-Length: ";
   localparam logic [127:0] HDR_TIME_TEXT   = 128'h582D_4368_6172_6765_2D54_696D_653A_2000;
   localparam logic [127:0] HDR_EVENT_TEXT  = 128'h582D_4368_6172_6765_2D45_7665_6E74_3A20;

   localparam logic [2:0][127:0] HDR_TEXT = {HDR_EVENT_TEXT, HDR_TIME_TEXT, HDR_LENGTH_TEXT};
   localparam logic [2:0][4:0]   HDR_LEN  = {5'd16, 5'd15, 5'd16};

   // Event names, first character in the top byte.
   localparam logic [2:0][63:0] EV_TEXT = {{"handled", 8'h00}, "outgoing", "incoming"};
   localparam logic [2:0][3:0]  EV_LEN  = {4'd7, 4'd8, 4'd8};

   // Limits of the magnitude of a signed 64-bit time.
   localparam logic [67:0] TIME_POS_LIM = 68'h0_7FFF_FFFF_FFFF_FFFF;
   localparam logic [67:0] TIME_NEG_LIM = 68'h0_8000_0000_0000_0000;

endpackage

>>> sv/content_length_log_deframer_unit.sv
// Channel  | Direction | tdata (low bit up)                       | tuser       | tlast
// req_     | in        | data_byte[7:0]                           | -           | end_of_data
// rsp_     | out       | time_us, event_kind, content_length,     | result_kind | last_of_entry
//          |           | content_byte, error_code, zero pad       |             |
//
// One byte is taken per cycle while req_tready is high; each byte is parsed in the
// cycle it is accepted, and its results land in a four-entry output queue feeding rsp_.
// A byte gives at most one result, plus one truncation error at end of data.
// reset is synchronous and clears the parser and the queue; no clearing pass is needed.
// req_tready drops when the queue has fewer than two free entries, so a stall on rsp_
// holds back req_ after three queued items.
module content_length_log_deframer_unit #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // data_byte[7:0]
   input  logic [clld_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // time_us[63:0], event_kind[65:64], content_length[97:66], content_byte[105:98],
   // error_code[107:106], zero[111:108]
   output logic [clld_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // result_kind[1:0]
   output logic [clld_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   output logic                                  rsp_tlast
);
   import clld_pkg::*;

   localparam logic [LENGTH_BITS:0] LEN_OVER = {1'b1, {LENGTH_BITS{1'b0}}};

   // Parser state.
   mode_type                mode_ff, mode_in;
   logic                    entry_started_ff, entry_started_in;
   logic                    pending_cr_ff, pending_cr_in;
   logic [4:0]              line_pos_ff, line_pos_in;
   line_kind_type           line_kind_ff, line_kind_in;
   logic [2:0]              prefix_alive_ff, prefix_alive_in;
   logic [LENGTH_BITS:0]    length_accum_ff, length_accum_in;
   len_status_type          length_status_ff, length_status_in;
   logic [63:0]             time_value_ff, time_value_in;
   logic [63:0]             time_accum_ff, time_accum_in;
   num_status_type          num_status_ff, num_status_in;
   logic [1:0]              event_value_ff, event_value_in;
   logic [2:0]              event_cand_ff, event_cand_in;
   logic [LENGTH_BITS-1:0]  bytes_left_ff, bytes_left_in;

   // Output queue.
   rsp_item_type                  queue_ff [RSP_QUEUE_DEPTH];
   logic [RSP_QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_QUEUE_PTR_BITS:0]   count_ff, count_in;

   logic                    req_fire;
   logic                    rsp_pop;
   logic [7:0]              ch;
   logic [2:0]              hdr_match;
   logic [2:0]              ev_match;
   logic [2:0]              alive;
   logic                    is_digit;
   logic [3:0]              digit;
   num_status_type          num_digit_st;
   logic [67:0]             time_prod;
   logic [67:0]             time_lim;
   logic [LENGTH_BITS+4:0]  len_prod;
   logic [63:0]             time_commit;
   logic [63:0]             len_wide;
   logic                    do_char;
   logic                    do_end;
   logic [1:0]              push_cnt;
   rsp_item_type            res0, res1, head;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_pop  = rsp_tvalid && rsp_tready;

   // A CR held from the previous byte is handled as a plain line character first;
   // whatever follows it on that line can no longer change the outcome.
   assign ch = pending_cr_ff ? CHAR_CR : req_tdata[7:0];

   // Character matches against the header prefixes and event names.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hdr_match[k] = (line_pos_ff < HDR_LEN[k]) &&
                        (HDR_TEXT[k][{~line_pos_ff[3:0], 3'b000} +: 8] == ch);
         ev_match[k]  = (line_pos_ff < {1'b0, EV_LEN[k]}) &&
                        (EV_TEXT[k][{~line_pos_ff[2:0], 3'b000} +: 8] == ch);
      end
   end
   assign alive = prefix_alive_ff & hdr_match;

   // Digit step of the number scan: times ten plus digit, as shift and add.
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign digit    = 4'(ch - CHAR_ZERO);

   always_comb begin
      unique case (num_status_ff)
         NUM_START: num_digit_st = NUM_POS;
         NUM_MINUS: num_digit_st = NUM_NEG;
         default:   num_digit_st = num_status_ff;
      endcase
   end

   assign time_prod = ({4'b0, time_accum_ff} << 3) + ({4'b0, time_accum_ff} << 1) +
                      {64'b0, digit};
   assign time_lim  = (num_digit_st == NUM_NEG) ? TIME_NEG_LIM : TIME_POS_LIM;
   assign len_prod  = ({4'b0, length_accum_ff} << 3) + ({4'b0, length_accum_ff} << 1) +
                      (LENGTH_BITS+5)'(digit);

   // Time that a finished time line leaves behind.
   always_comb begin
      unique case (num_status_ff)
         NUM_POS: time_commit = time_accum_ff;
         NUM_NEG: time_commit = 64'd0 - time_accum_ff;
         default: time_commit = time_value_ff;
      endcase
   end

   assign len_wide = 64'(length_accum_ff);

   // Next parser state and the result items of the accepted byte.
   always_comb begin
      mode_in          = mode_ff;
      entry_started_in = entry_started_ff;
      pending_cr_in    = pending_cr_ff;
      line_pos_in      = line_pos_ff;
      line_kind_in     = line_kind_ff;
      prefix_alive_in  = prefix_alive_ff;
      length_accum_in  = length_accum_ff;
      length_status_in = length_status_ff;
      time_value_in    = time_value_ff;
      time_accum_in    = time_accum_ff;
      num_status_in    = num_status_ff;
      event_value_in   = event_value_ff;
      event_cand_in    = event_cand_ff;
      bytes_left_in    = bytes_left_ff;
      res0             = '0;
      res1             = '0;
      push_cnt         = 2'd0;
      do_char          = 1'b0;
      do_end           = 1'b0;

      // Line splitting in header mode, or one content byte in content mode.
      if (req_fire && mode_ff != MODE_STOPPED) begin
         if (mode_ff == MODE_HEADER) begin
            entry_started_in = 1'b1;
            if (pending_cr_ff) begin
               pending_cr_in = 1'b0;
               if (req_tdata[7:0] == CHAR_LF) begin
                  do_end = 1'b1;
               end else begin
                  do_char = 1'b1;
                  if (req_tdata[7:0] == CHAR_CR) begin
                     pending_cr_in = 1'b1;
                  end
               end
            end else if (req_tdata[7:0] == CHAR_CR) begin
               pending_cr_in = 1'b1;
            end else begin
               do_char = 1'b1;
            end
         end else begin
            res0.kind           = RESULT_BYTE;
            res0.time_us        = time_value_ff;
            res0.event_kind     = event_value_ff;
            res0.content_length = len_wide[31:0];
            res0.content_byte   = req_tdata[7:0];
            res0.last           = (bytes_left_ff == LENGTH_BITS'(1));
            push_cnt            = 2'd1;
            bytes_left_in       = bytes_left_ff - LENGTH_BITS'(1);
            if (bytes_left_ff == LENGTH_BITS'(1)) begin
               mode_in          = MODE_HEADER;
               entry_started_in = 1'b0;
               pending_cr_in    = 1'b0;
               line_pos_in      = 5'd0;
               line_kind_in     = LINE_UNDECIDED;
               prefix_alive_in  = 3'b111;
               num_status_in    = NUM_START;
               event_cand_in    = 3'b111;
               length_accum_in  = '0;
               length_status_in = LEN_UNSET;
               time_value_in    = 64'd0;
               time_accum_in    = 64'd0;
               event_value_in   = 2'd0;
               bytes_left_in    = '0;
            end
         end
      end

      // One character of a header line.
      if (do_char) begin
         unique case (line_kind_ff)
            LINE_UNDECIDED: begin
               prefix_alive_in = alive;
               priority if (alive == 3'b000) begin
                  line_kind_in = LINE_OTHER;
               end else if (alive[0] && (line_pos_ff + 5'd1 == HDR_LEN[0])) begin
                  line_kind_in    = LINE_LENGTH;
                  line_pos_in     = 5'd0;
                  num_status_in   = NUM_START;
                  event_cand_in   = 3'b111;
                  length_accum_in = '0;
               end else if (alive[1] && (line_pos_ff + 5'd1 == HDR_LEN[1])) begin
                  line_kind_in  = LINE_TIME;
                  line_pos_in   = 5'd0;
                  num_status_in = NUM_START;
                  event_cand_in = 3'b111;
                  time_accum_in = 64'd0;
               end else if (alive[2] && (line_pos_ff + 5'd1 == HDR_LEN[2])) begin
                  line_kind_in  = LINE_EVENT;
                  line_pos_in   = 5'd0;
                  num_status_in = NUM_START;
                  event_cand_in = 3'b111;
               end else begin
                  line_pos_in = line_pos_ff + 5'd1;
               end
            end
            LINE_LENGTH, LINE_TIME: begin
               if (num_status_ff != NUM_DONE && num_status_ff != NUM_BROKEN) begin
                  priority if (ch == CHAR_MINUS && num_status_ff == NUM_START) begin
                     num_status_in = NUM_MINUS;
                  end else if (is_digit) begin
                     if (line_kind_ff == LINE_TIME) begin
                        if (time_prod > time_lim) begin
                           num_status_in = NUM_BROKEN;
                        end else begin
                           time_accum_in = time_prod[63:0];
                           num_status_in = num_digit_st;
                        end
                     end else if (num_digit_st == NUM_NEG) begin
                        num_status_in = (digit != 4'd0) ? NUM_BROKEN : NUM_NEG;
                     end else begin
                        length_accum_in = (|len_prod[LENGTH_BITS+4:LENGTH_BITS]) ?
                                          LEN_OVER : len_prod[LENGTH_BITS:0];
                        num_status_in   = NUM_POS;
                     end
                  end else if (line_kind_ff == LINE_TIME) begin
                     // The digit run ends at the first other character.
                     time_value_in = time_commit;
                     num_status_in = NUM_DONE;
                  end else begin
                     num_status_in = NUM_BROKEN;
                  end
               end
            end
            LINE_EVENT: begin
               event_cand_in = event_cand_ff & ev_match;
               if (line_pos_ff != 5'd31) begin
                  line_pos_in = line_pos_ff + 5'd1;
               end
            end
            default: begin
            end
         endcase
      end

      // End of a header line; an empty line closes the header block.
      if (do_end) begin
         if (line_kind_ff == LINE_UNDECIDED && line_pos_ff == 5'd0) begin
            priority if (length_status_ff == LEN_UNSET || length_status_ff == LEN_BAD) begin
               res0.kind       = RESULT_ERROR;
               res0.error_code = ERR_BAD_LENGTH;
               push_cnt        = 2'd1;
               mode_in         = MODE_STOPPED;
            end else if (length_status_ff == LEN_LARGE) begin
               res0.kind       = RESULT_ERROR;
               res0.error_code = ERR_TOO_LARGE;
               push_cnt        = 2'd1;
               mode_in         = MODE_STOPPED;
            end else begin
               res0.kind           = RESULT_HEADER;
               res0.time_us        = time_value_ff;
               res0.event_kind     = event_value_ff;
               res0.content_length = len_wide[31:0];
               res0.last           = (length_accum_ff == '0);
               push_cnt            = 2'd1;
               if (length_accum_ff == '0) begin
                  mode_in          = MODE_HEADER;
                  entry_started_in = 1'b0;
                  pending_cr_in    = 1'b0;
                  line_pos_in      = 5'd0;
                  line_kind_in     = LINE_UNDECIDED;
                  prefix_alive_in  = 3'b111;
                  num_status_in    = NUM_START;
                  event_cand_in    = 3'b111;
                  length_accum_in  = '0;
                  length_status_in = LEN_UNSET;
                  time_value_in    = 64'd0;
                  time_accum_in    = 64'd0;
                  event_value_in   = 2'd0;
                  bytes_left_in    = '0;
               end else begin
                  mode_in       = MODE_CONTENT;
                  bytes_left_in = length_accum_ff[LENGTH_BITS-1:0];
               end
            end
         end else begin
            if (line_kind_ff == LINE_LENGTH) begin
               unique case (num_status_ff)
                  NUM_POS: length_status_in = length_accum_ff[LENGTH_BITS] ? LEN_LARGE :
                                                                             LEN_VALID;
                  NUM_NEG: length_status_in = LEN_VALID;
                  default: length_status_in = LEN_BAD;
               endcase
            end else if (line_kind_ff == LINE_TIME) begin
               time_value_in = time_commit;
            end else if (line_kind_ff == LINE_EVENT) begin
               for (int k = 0; k < 3; k++) begin
                  if (event_cand_ff[k] && line_pos_ff == {1'b0, EV_LEN[k]}) begin
                     event_value_in = 2'(k);
                  end
               end
            end
            line_pos_in     = 5'd0;
            line_kind_in    = LINE_UNDECIDED;
            prefix_alive_in = 3'b111;
            num_status_in   = NUM_START;
            event_cand_in   = 3'b111;
         end
      end

      // End of data inside an entry stops the block with a truncation error.
      if (req_fire && mode_ff != MODE_STOPPED && req_tlast && mode_in != MODE_STOPPED &&
          (mode_in == MODE_CONTENT || entry_started_in)) begin
         if (push_cnt == 2'd0) begin
            res0.kind       = RESULT_ERROR;
            res0.error_code = ERR_TRUNCATED;
         end else begin
            res1.kind       = RESULT_ERROR;
            res1.error_code = ERR_TRUNCATED;
         end
         push_cnt = push_cnt + 2'd1;
         mode_in  = MODE_STOPPED;
      end
   end

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_HEADER;
         entry_started_ff <= 1'b0;
         pending_cr_ff    <= 1'b0;
         line_pos_ff      <= 5'd0;
         line_kind_ff     <= LINE_UNDECIDED;
         prefix_alive_ff  <= 3'b111;
         length_accum_ff  <= '0;
         length_status_ff <= LEN_UNSET;
         time_value_ff    <= 64'd0;
         time_accum_ff    <= 64'd0;
         num_status_ff    <= NUM_START;
         event_value_ff   <= 2'd0;
         event_cand_ff    <= 3'b111;
         bytes_left_ff    <= '0;
      end else begin
         mode_ff          <= mode_in;
         entry_started_ff <= entry_started_in;
         pending_cr_ff    <= pending_cr_in;
         line_pos_ff      <= line_pos_in;
         line_kind_ff     <= line_kind_in;
         prefix_alive_ff  <= prefix_alive_in;
         length_accum_ff  <= length_accum_in;
         length_status_ff <= length_status_in;
         time_value_ff    <= time_value_in;
         time_accum_ff    <= time_accum_in;
         num_status_ff    <= num_status_in;
         event_value_ff   <= event_value_in;
         event_cand_ff    <= event_cand_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

   // Output queue pointers and fill count.
   assign wr_ptr_in = wr_ptr_ff + RSP_QUEUE_PTR_BITS'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + RSP_QUEUE_PTR_BITS'(rsp_pop);
   assign count_in  = count_ff + (RSP_QUEUE_PTR_BITS+1)'(push_cnt) -
                      (RSP_QUEUE_PTR_BITS+1)'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; up to two items are written per cycle.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + RSP_QUEUE_PTR_BITS'(1)] <= res1;
      end
   end

   // Input is taken while two queue entries are free.
   assign req_tready = (count_ff <= (RSP_QUEUE_PTR_BITS+1)'(RSP_QUEUE_DEPTH - 2));

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {4'b0, head.error_code, head.content_byte, head.content_length,
                        head.event_kind, head.time_us};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // Once stopped, only reset brings the parser back.
   a_stopped_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STOPPED |=> mode_ff == MODE_STOPPED)
      else $error("parser left the stopped mode without reset");

   // Content mode always has bytes still to come.
   a_content_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_CONTENT |-> bytes_left_ff != '0)
      else $error("content mode with no bytes left");

   // A held CR belongs to header parsing only.
   a_cr_in_header: assert property (@(posedge clock) disable iff (reset)
      pending_cr_ff |-> mode_ff != MODE_CONTENT)
      else $error("pending CR while in content mode");

   // An undecided line never runs past the longest header prefix.
   a_prefix_pos: assert property (@(posedge clock) disable iff (reset)
      line_kind_ff == LINE_UNDECIDED |-> line_pos_ff <= 5'd15)
      else $error("undecided line position beyond prefix length");

   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (RSP_QUEUE_PTR_BITS+1)'(RSP_QUEUE_DEPTH))
      else $error("output queue overflow");

endmodule
